@@ design/fsr_pkg.sv @@
// Shared types and constants for the framed serial receiver.
package fsr_pkg;

	localparam int FRAME_SLOTS_DEF = 8;
	localparam int MAX_LEN_DEF = 40;
	localparam int MIN_LEN = 4;
	localparam int FH_W = 3;
	localparam int FLEN_W = 6;
	localparam int QUEUE_DEPTH = 2;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic REG_START = 1'b0;
	localparam logic REG_STOP = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_ACCEPT = 3'd1,
		ST_BAD_CHECK = 3'd2,
		ST_BAD_LEN = 3'd3,
		ST_FULL = 3'd4,
		ST_PAYLOAD = 3'd5,
		ST_EMPTY = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		RX_HUNT,
		RX_LEN,
		RX_BODY
	} rx_state_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_FETCH,
		BK_LEN,
		BK_NEXT,
		BK_DATA
	} bk_state_t;

	typedef struct packed {
		logic is_read;
		status_t status;
		logic [FH_W-1:0] frames_held;
	} job_t;

endpackage

@@ design/framed_serial_receiver_ring.sv @@
// Top level of the framed serial receiver with its ring of payload slots.
//
//  channel  | direction | handshake        | contents
//  s_*      | in        | s_tvalid/tready  | command in tuser, rx_byte in tdata
//  m_*      | out       | m_tvalid/tready  | results per item, tlast on the final
//  APB      | in        | psel/penable     | start_byte at 0x0, stop_byte at 0x4
//
// The front end takes one item per cycle while the two-entry job queue has room.
// A receive or empty-ring read gives its one result. A frame read fetches its length
// from the slot table in the FETCH and LEN states, then uses DATA and NEXT for each
// payload byte, as the payload memory has a registered read port. Reset clears the
// state machines and slot pointers; the ring memories need no clearing pass.
// A stalled output holds its result while the front end fills the job queue.
module framed_serial_receiver_ring #(
	parameter int FRAME_SLOTS = fsr_pkg::FRAME_SLOTS_DEF,
	parameter int MAX_LEN = fsr_pkg::MAX_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	input  logic s_tuser,         // [0] command
	output logic m_tvalid,
	input  logic m_tready,
	output logic [23:0] m_tdata,  // [7:0] data_byte, [10:8] frames_held, [16:11] frame_length
	output logic [3:0] m_tuser,   // [2:0] status, [3] byte_valid
	output logic m_tlast,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int SLOT_BYTES = MAX_LEN - fsr_pkg::MIN_LEN;
	localparam int SLOT_W = $clog2(FRAME_SLOTS);
	localparam int LEN_W = $clog2(SLOT_BYTES + 1);
	localparam int ADDR_W = $clog2(FRAME_SLOTS * SLOT_BYTES);

	logic [7:0] start_q;
	logic [7:0] stop_q;
	logic cfg_wr;

	logic job_valid;
	logic job_ready;
	fsr_pkg::job_t job_in;
	logic q_valid;
	logic q_pop;
	fsr_pkg::job_t q_job;

	logic pw_en;
	logic [ADDR_W-1:0] pw_addr;
	logic [7:0] pw_data;
	logic lw_en;
	logic [SLOT_W-1:0] lw_slot;
	logic [LEN_W-1:0] lw_len;

	fsr_pkg::status_t status;
	logic [7:0] data_byte;
	logic byte_valid;
	logic [fsr_pkg::FH_W-1:0] frames_held;
	logic [fsr_pkg::FLEN_W-1:0] frame_length;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == fsr_pkg::REG_STOP) ? {24'd0, stop_q} : {24'd0, start_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 8'd2;
			stop_q <= 8'd3;
		end else if (cfg_wr) begin
			if (paddr[2] == fsr_pkg::REG_START) begin
				start_q <= pwdata[7:0];
			end else begin
				stop_q <= pwdata[7:0];
			end
		end
	end

	fsr_front #(
		.FRAME_SLOTS(FRAME_SLOTS),
		.MAX_LEN(MAX_LEN)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.command(s_tuser),
		.rx_byte(s_tdata),
		.start_byte(start_q),
		.stop_byte(stop_q),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job(job_in),
		.pw_en(pw_en),
		.pw_addr(pw_addr),
		.pw_data(pw_data),
		.lw_en(lw_en),
		.lw_slot(lw_slot),
		.lw_len(lw_len)
	);

	fsr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(job_valid),
		.push_ready(job_ready),
		.push_job(job_in),
		.pop_valid(q_valid),
		.pop_ready(q_pop),
		.pop_job(q_job)
	);

	fsr_back #(
		.FRAME_SLOTS(FRAME_SLOTS),
		.MAX_LEN(MAX_LEN)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(q_valid),
		.job_pop(q_pop),
		.job(q_job),
		.pw_en(pw_en),
		.pw_addr(pw_addr),
		.pw_data(pw_data),
		.lw_en(lw_en),
		.lw_slot(lw_slot),
		.lw_len(lw_len),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.status(status),
		.data_byte(data_byte),
		.byte_valid(byte_valid),
		.last(m_tlast),
		.frames_held(frames_held),
		.frame_length(frame_length)
	);

	assign m_tdata = {7'd0, frame_length, frames_held, data_byte};
	assign m_tuser = {byte_valid, status};

	a_valid_is_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && byte_valid |-> status == fsr_pkg::ST_PAYLOAD)
		else $error("payload byte flagged with a non-payload status");

	a_single_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status != fsr_pkg::ST_PAYLOAD |-> m_tlast)
		else $error("single-result item not marked last");

	a_no_len_without_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !byte_valid |-> frame_length == '0 && data_byte == 8'd0)
		else $error("length or data shown on a result without a payload byte");

	a_read_mid_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && byte_valid && !m_tlast |-> frame_length != '0 || MAX_LEN > 67)
		else $error("frame read out with a zero length mid-frame");

endmodule

@@ design/fsr_front.sv @@
// Front end: accepts items, parses frames, writes payload, and queues one job per item.
module fsr_front #(
	parameter int FRAME_SLOTS = fsr_pkg::FRAME_SLOTS_DEF,
	parameter int MAX_LEN = fsr_pkg::MAX_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic command,
	input  logic [7:0] rx_byte,
	input  logic [7:0] start_byte,
	input  logic [7:0] stop_byte,
	output logic job_valid,
	input  logic job_ready,
	output fsr_pkg::job_t job,
	output logic pw_en,
	output logic [$clog2(FRAME_SLOTS*(MAX_LEN-fsr_pkg::MIN_LEN))-1:0] pw_addr,
	output logic [7:0] pw_data,
	output logic lw_en,
	output logic [$clog2(FRAME_SLOTS)-1:0] lw_slot,
	output logic [$clog2(MAX_LEN-fsr_pkg::MIN_LEN+1)-1:0] lw_len
);

	localparam int SLOT_BYTES = MAX_LEN - fsr_pkg::MIN_LEN;
	localparam int SLOT_W = $clog2(FRAME_SLOTS);
	localparam int LEN_W = $clog2(SLOT_BYTES + 1);
	localparam int ADDR_W = $clog2(FRAME_SLOTS * SLOT_BYTES);
	localparam int POS_W = $clog2(MAX_LEN + 1);

	fsr_pkg::rx_state_t rx_state_q, rx_state_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [POS_W-1:0] decl_q, decl_d;
	logic [7:0] xor_q, xor_d;
	logic chk_q, chk_d;
	logic [ADDR_W-1:0] wptr_q, wptr_d;
	logic [ADDR_W-1:0] wbase_q, wbase_d;
	logic [SLOT_W-1:0] wslot_q, wslot_d;
	logic [SLOT_W-1:0] rslot_q, rslot_d;
	logic [SLOT_W-1:0] held;
	logic accept;

	assign in_ready = job_ready;
	assign accept = in_valid && job_ready;
	assign job_valid = accept;
	assign pw_addr = wptr_q;
	assign pw_data = rx_byte;
	assign lw_slot = wslot_q;
	assign lw_len = LEN_W'(decl_q - POS_W'(fsr_pkg::MIN_LEN));

	always_comb begin
		if (wslot_q >= rslot_q) begin
			held = wslot_q - rslot_q;
		end else begin
			held = SLOT_W'({1'b0, wslot_q} + (SLOT_W+1)'(FRAME_SLOTS) - {1'b0, rslot_q});
		end
	end

	always_comb begin
		rx_state_d = rx_state_q;
		pos_d = pos_q;
		decl_d = decl_q;
		xor_d = xor_q;
		chk_d = chk_q;
		wptr_d = wptr_q;
		wbase_d = wbase_q;
		wslot_d = wslot_q;
		rslot_d = rslot_q;
		pw_en = 1'b0;
		lw_en = 1'b0;
		job.is_read = 1'b0;
		job.status = fsr_pkg::ST_IDLE;
		job.frames_held = fsr_pkg::FH_W'(held);
		if (accept) begin
			if (!command) begin
				unique case (rx_state_q)
					fsr_pkg::RX_HUNT: begin
						if (rx_byte == start_byte) begin
							rx_state_d = fsr_pkg::RX_LEN;
						end
					end
					fsr_pkg::RX_LEN: begin
						if (rx_byte < 8'(fsr_pkg::MIN_LEN) || rx_byte > 8'(MAX_LEN)) begin
							rx_state_d = fsr_pkg::RX_HUNT;
							job.status = fsr_pkg::ST_BAD_LEN;
						end else begin
							rx_state_d = fsr_pkg::RX_BODY;
							decl_d = POS_W'(rx_byte);
							xor_d = rx_byte;
							pos_d = POS_W'(2);
							wptr_d = wbase_q;
						end
					end
					fsr_pkg::RX_BODY: begin
						if (pos_q < decl_q - POS_W'(2)) begin
							pw_en = 1'b1;
							wptr_d = wptr_q + 1'b1;
							xor_d = xor_q ^ rx_byte;
							pos_d = pos_q + 1'b1;
						end else if (pos_q == decl_q - POS_W'(2)) begin
							chk_d = (rx_byte == xor_q);
							pos_d = pos_q + 1'b1;
						end else begin
							rx_state_d = fsr_pkg::RX_HUNT;
							if (!chk_q || rx_byte != stop_byte) begin
								job.status = fsr_pkg::ST_BAD_CHECK;
							end else if (held == SLOT_W'(FRAME_SLOTS - 1)) begin
								job.status = fsr_pkg::ST_FULL;
							end else begin
								job.status = fsr_pkg::ST_ACCEPT;
								job.frames_held = fsr_pkg::FH_W'(held + 1'b1);
								lw_en = 1'b1;
								if (wslot_q == SLOT_W'(FRAME_SLOTS - 1)) begin
									wslot_d = '0;
									wbase_d = '0;
								end else begin
									wslot_d = wslot_q + 1'b1;
									wbase_d = wbase_q + ADDR_W'(SLOT_BYTES);
								end
							end
						end
					end
					default: rx_state_d = fsr_pkg::RX_HUNT;
				endcase
			end else if (held == '0) begin
				job.status = fsr_pkg::ST_EMPTY;
			end else begin
				job.is_read = 1'b1;
				job.status = fsr_pkg::ST_PAYLOAD;
				job.frames_held = fsr_pkg::FH_W'(held - 1'b1);
				if (rslot_q == SLOT_W'(FRAME_SLOTS - 1)) begin
					rslot_d = '0;
				end else begin
					rslot_d = rslot_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_state_q <= fsr_pkg::RX_HUNT;
		end else begin
			rx_state_q <= rx_state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wslot_q <= '0;
			rslot_q <= '0;
			wbase_q <= '0;
		end else begin
			wslot_q <= wslot_d;
			rslot_q <= rslot_d;
			wbase_q <= wbase_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		decl_q <= decl_d;
		xor_q <= xor_d;
		chk_q <= chk_d;
		wptr_q <= wptr_d;
	end

endmodule

@@ design/fsr_queue.sv @@
// Two-entry job queue between the front end and the back end.
module fsr_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  fsr_pkg::job_t push_job,
	output logic pop_valid,
	input  logic pop_ready,
	output fsr_pkg::job_t pop_job
);

	fsr_pkg::job_t entry_q [fsr_pkg::QUEUE_DEPTH];
	logic [fsr_pkg::QCNT_W-1:0] count_q;
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != fsr_pkg::QCNT_W'(fsr_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_job = entry_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

@@ design/fsr_back.sv @@
// Back end: holds the frame ring and streams results into the output register.
module fsr_back #(
	parameter int FRAME_SLOTS = fsr_pkg::FRAME_SLOTS_DEF,
	parameter int MAX_LEN = fsr_pkg::MAX_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_pop,
	input  fsr_pkg::job_t job,
	input  logic pw_en,
	input  logic [$clog2(FRAME_SLOTS*(MAX_LEN-fsr_pkg::MIN_LEN))-1:0] pw_addr,
	input  logic [7:0] pw_data,
	input  logic lw_en,
	input  logic [$clog2(FRAME_SLOTS)-1:0] lw_slot,
	input  logic [$clog2(MAX_LEN-fsr_pkg::MIN_LEN+1)-1:0] lw_len,
	output logic out_valid,
	input  logic out_ready,
	output fsr_pkg::status_t status,
	output logic [7:0] data_byte,
	output logic byte_valid,
	output logic last,
	output logic [fsr_pkg::FH_W-1:0] frames_held,
	output logic [fsr_pkg::FLEN_W-1:0] frame_length
);

	localparam int SLOT_BYTES = MAX_LEN - fsr_pkg::MIN_LEN;
	localparam int SLOT_W = $clog2(FRAME_SLOTS);
	localparam int LEN_W = $clog2(SLOT_BYTES + 1);
	localparam int ADDR_W = $clog2(FRAME_SLOTS * SLOT_BYTES);
	localparam int DEPTH = FRAME_SLOTS * SLOT_BYTES;

	logic [7:0] pay_mem [DEPTH];
	logic [LEN_W-1:0] len_mem [FRAME_SLOTS];
	logic [7:0] pay_rd_q;
	logic [LEN_W-1:0] len_rd_q;

	fsr_pkg::bk_state_t state_q, state_d;
	logic [SLOT_W-1:0] rslot_q;
	logic [ADDR_W-1:0] rbase_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] cnt_q;
	logic [fsr_pkg::FH_W-1:0] fh_q;
	logic out_valid_q;
	fsr_pkg::status_t status_q;
	logic [7:0] data_q;
	logic valid_q;
	logic last_q;
	logic [fsr_pkg::FH_W-1:0] held_q;
	logic [fsr_pkg::FLEN_W-1:0] flen_q;

	logic out_free;
	logic start_read;
	logic take_len;
	logic step_addr;
	logic load_single;
	logic load_byte;
	logic load_zero;
	logic is_final;

	assign out_free = !out_valid_q || out_ready;
	assign is_final = (LEN_W'(cnt_q + 1'b1) == len_q);

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign data_byte = data_q;
	assign byte_valid = valid_q;
	assign last = last_q;
	assign frames_held = held_q;
	assign frame_length = flen_q;

	always_ff @(posedge clk) begin
		if (pw_en) begin
			pay_mem[pw_addr] <= pw_data;
		end
		pay_rd_q <= pay_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (lw_en) begin
			len_mem[lw_slot] <= lw_len;
		end
		len_rd_q <= len_mem[rslot_q];
	end

	always_comb begin
		state_d = state_q;
		job_pop = 1'b0;
		start_read = 1'b0;
		take_len = 1'b0;
		step_addr = 1'b0;
		load_single = 1'b0;
		load_byte = 1'b0;
		load_zero = 1'b0;
		unique case (state_q)
			fsr_pkg::BK_IDLE: begin
				if (job_valid) begin
					if (job.is_read) begin
						job_pop = 1'b1;
						start_read = 1'b1;
						state_d = fsr_pkg::BK_FETCH;
					end else if (out_free) begin
						job_pop = 1'b1;
						load_single = 1'b1;
					end
				end
			end
			fsr_pkg::BK_FETCH: state_d = fsr_pkg::BK_LEN;
			fsr_pkg::BK_LEN: begin
				take_len = 1'b1;
				state_d = fsr_pkg::BK_DATA;
			end
			fsr_pkg::BK_NEXT: state_d = fsr_pkg::BK_DATA;
			fsr_pkg::BK_DATA: begin
				if (out_free) begin
					if (len_q == '0) begin
						load_zero = 1'b1;
						state_d = fsr_pkg::BK_IDLE;
					end else begin
						load_byte = 1'b1;
						if (is_final) begin
							state_d = fsr_pkg::BK_IDLE;
						end else begin
							step_addr = 1'b1;
							state_d = fsr_pkg::BK_NEXT;
						end
					end
				end
			end
			default: state_d = fsr_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsr_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rslot_q <= '0;
			rbase_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take_len) begin
				if (rslot_q == SLOT_W'(FRAME_SLOTS - 1)) begin
					rslot_q <= '0;
					rbase_q <= '0;
				end else begin
					rslot_q <= rslot_q + 1'b1;
					rbase_q <= rbase_q + ADDR_W'(SLOT_BYTES);
				end
			end
			if (load_single || load_byte || load_zero) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_read) begin
			addr_q <= rbase_q;
			fh_q <= job.frames_held;
		end else if (step_addr) begin
			addr_q <= addr_q + 1'b1;
		end
		if (take_len) begin
			len_q <= len_rd_q;
			cnt_q <= '0;
		end else if (step_addr) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (load_single) begin
			status_q <= job.status;
			data_q <= '0;
			valid_q <= 1'b0;
			last_q <= 1'b1;
			held_q <= job.frames_held;
			flen_q <= '0;
		end else if (load_zero) begin
			status_q <= fsr_pkg::ST_PAYLOAD;
			data_q <= '0;
			valid_q <= 1'b0;
			last_q <= 1'b1;
			held_q <= fh_q;
			flen_q <= '0;
		end else if (load_byte) begin
			status_q <= fsr_pkg::ST_PAYLOAD;
			data_q <= pay_rd_q;
			valid_q <= 1'b1;
			last_q <= is_final;
			held_q <= fh_q;
			flen_q <= fsr_pkg::FLEN_W'(len_q);
		end
	end

endmodule

@@ tb/tb_framed_serial_receiver_ring.sv @@
// Self-checking testbench for the framed serial receiver: frame stimulus, predictor and result check.
module tb_framed_serial_receiver_ring;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = fsr_pkg::FRAME_SLOTS_DEF;
	localparam int LEN_MAX = fsr_pkg::MAX_LEN_DEF;
	localparam int SLOT_BYTES = fsr_pkg::MAX_LEN_DEF - fsr_pkg::MIN_LEN;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 20;
	localparam int DRAIN_CYCLES = 200;
	localparam logic CMD_RX = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef struct packed {
		logic cmd;
		logic [7:0] b;
		logic typed;
		fsr_pkg::status_t st;
		logic [fsr_pkg::FH_W-1:0] held;
	} row_t;

	typedef struct packed {
		fsr_pkg::status_t status;
		logic [7:0] data;
		logic valid;
		logic last;
		logic [fsr_pkg::FH_W-1:0] held;
		logic [fsr_pkg::FLEN_W-1:0] flen;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;   // [7:0] rx_byte
	logic s_tuser = 1'b0;          // [0] command
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;          // [7:0] data_byte, [10:8] frames_held, [16:11] frame_length
	logic [3:0] m_tuser;           // [2:0] status, [3] byte_valid
	logic m_tlast;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic pready;

	framed_serial_receiver_ring dut (.*);

	always #6 clk = ~clk;

	// Receiver state as the block should hold it.
	logic [7:0] cfg_start = 8'h02;
	logic [7:0] cfg_stop = 8'h03;
	bit rx_open = 1'b0;
	int rx_pos = 0;
	int rx_len = 0;
	logic [7:0] rx_xor = 8'h00;
	bit rx_ok = 1'b0;
	logic [7:0] ring_bytes[SLOTS][SLOT_BYTES];
	int ring_len[SLOTS];
	int wr_slot = 0;
	int rd_slot = 0;

	row_t stim_q[$];
	result_t expected_results[$];
	row_t bus_row;
	bit took = 1'b0;
	int src_idle_pct = 0;
	int dst_idle_pct = 0;
	int failures = 0;
	int items_taken = 0;
	int results_checked = 0;
	int full_drops = 0;
	int unsigned cycles = 0;

	// The expected result is typed in only for rows whose outcome is plain from the frame rules.
	row_t directed_rows[26] = '{
		'{CMD_READ, 8'h00, 1'b1, fsr_pkg::ST_EMPTY, 3'd0},
		'{CMD_RX, 8'h00, 1'b1, fsr_pkg::ST_IDLE, 3'd0},
		'{CMD_RX, 8'hFF, 1'b1, fsr_pkg::ST_IDLE, 3'd0},
		'{CMD_RX, 8'h02, 1'b1, fsr_pkg::ST_IDLE, 3'd0},
		'{CMD_RX, 8'h03, 1'b1, fsr_pkg::ST_BAD_LEN, 3'd0},
		'{CMD_RX, 8'h02, 1'b1, fsr_pkg::ST_IDLE, 3'd0},
		'{CMD_RX, 8'hFF, 1'b1, fsr_pkg::ST_BAD_LEN, 3'd0},
		'{CMD_RX, 8'h02, 1'b1, fsr_pkg::ST_IDLE, 3'd0},
		'{CMD_RX, 8'h04, 1'b1, fsr_pkg::ST_IDLE, 3'd0},
		'{CMD_RX, 8'h04, 1'b1, fsr_pkg::ST_IDLE, 3'd0},
		'{CMD_RX, 8'h03, 1'b1, fsr_pkg::ST_ACCEPT, 3'd1},
		'{CMD_READ, 8'hFF, 1'b1, fsr_pkg::ST_PAYLOAD, 3'd0},
		'{CMD_RX, 8'h02, 1'b0, fsr_pkg::ST_IDLE, 3'd0},
		'{CMD_RX, 8'h05, 1'b0, fsr_pkg::ST_IDLE, 3'd0},
		'{CMD_RX, 8'h02, 1'b0, fsr_pkg::ST_IDLE, 3'd0},
		'{CMD_RX, 8'h07, 1'b0, fsr_pkg::ST_IDLE, 3'd0},
		'{CMD_RX, 8'h03, 1'b1, fsr_pkg::ST_ACCEPT, 3'd1},
		'{CMD_RX, 8'h02, 1'b0, fsr_pkg::ST_IDLE, 3'd0},
		'{CMD_RX, 8'h04, 1'b0, fsr_pkg::ST_IDLE, 3'd0},
		'{CMD_RX, 8'h00, 1'b0, fsr_pkg::ST_IDLE, 3'd0},
		'{CMD_RX, 8'h03, 1'b1, fsr_pkg::ST_BAD_CHECK, 3'd1},
		'{CMD_RX, 8'h02, 1'b0, fsr_pkg::ST_IDLE, 3'd0},
		'{CMD_RX, 8'h04, 1'b0, fsr_pkg::ST_IDLE, 3'd0},
		'{CMD_RX, 8'h04, 1'b0, fsr_pkg::ST_IDLE, 3'd0},
		'{CMD_RX, 8'h00, 1'b1, fsr_pkg::ST_BAD_CHECK, 3'd1},
		'{CMD_READ, 8'h00, 1'b0, fsr_pkg::ST_IDLE, 3'd0}
	};

	function automatic int frames_in_ring();
		return (wr_slot + SLOTS - rd_slot) % SLOTS;
	endfunction

	function automatic fsr_pkg::status_t take_byte(input logic [7:0] c);
		int pos;
		if (!rx_open) begin
			if (c == cfg_start) begin
				rx_open = 1'b1;
				rx_pos = 1;
				rx_xor = 8'h00;
				rx_ok = 1'b0;
				rx_len = 0;
			end
			return fsr_pkg::ST_IDLE;
		end
		pos = rx_pos;
		if (pos == 1) begin
			rx_len = int'(c);
			if (rx_len < fsr_pkg::MIN_LEN || rx_len > LEN_MAX) begin
				rx_open = 1'b0;
				rx_pos = 0;
				return fsr_pkg::ST_BAD_LEN;
			end
			rx_xor = c;
			rx_pos = 2;
			return fsr_pkg::ST_IDLE;
		end
		if (pos < rx_len - 2) begin
			ring_bytes[wr_slot][pos - 2] = c;
			rx_xor ^= c;
			rx_pos = pos + 1;
			return fsr_pkg::ST_IDLE;
		end
		if (pos == rx_len - 2) begin
			rx_ok = (c == rx_xor);
			rx_pos = pos + 1;
			return fsr_pkg::ST_IDLE;
		end
		rx_open = 1'b0;
		rx_pos = 0;
		if (!rx_ok || c != cfg_stop)
			return fsr_pkg::ST_BAD_CHECK;
		if (frames_in_ring() >= SLOTS - 1)
			return fsr_pkg::ST_FULL;
		ring_len[wr_slot] = rx_len - fsr_pkg::MIN_LEN;
		wr_slot = (wr_slot + 1) % SLOTS;
		return fsr_pkg::ST_ACCEPT;
	endfunction

	task automatic absorb(input row_t r);
		int n0, slot, n;
		result_t res;
		n0 = expected_results.size();
		res = '0;
		res.last = 1'b1;
		if (r.cmd == CMD_RX) begin
			res.status = take_byte(r.b);
			if (res.status == fsr_pkg::ST_FULL)
				full_drops++;
			res.held = fsr_pkg::FH_W'(frames_in_ring());
			expected_results.push_back(res);
		end else if (frames_in_ring() == 0) begin
			res.status = fsr_pkg::ST_EMPTY;
			expected_results.push_back(res);
		end else begin
			slot = rd_slot;
			n = ring_len[slot];
			rd_slot = (rd_slot + 1) % SLOTS;
			res.status = fsr_pkg::ST_PAYLOAD;
			res.held = fsr_pkg::FH_W'(frames_in_ring());
			if (n == 0)
				expected_results.push_back(res);
			for (int i = 0; i < n; i++) begin
				res.data = ring_bytes[slot][i];
				res.valid = 1'b1;
				res.last = (i == n - 1);
				res.flen = fsr_pkg::FLEN_W'(n);
				expected_results.push_back(res);
			end
		end
		if (r.typed) begin
			while (expected_results.size() > n0)
				expected_results.delete(expected_results.size() - 1);
			res = '0;
			res.status = r.st;
			res.last = 1'b1;
			res.held = r.held;
			expected_results.push_back(res);
		end
	endtask

	function automatic void compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	function automatic void put(input logic cmd, input logic [7:0] b);
		row_t r;
		r = '0;
		r.cmd = cmd;
		r.b = b;
		stim_q.push_back(r);
	endfunction

	// Mostly well-formed frames with random payload, mixed with reads, stray bytes and broken frames.
	task automatic queue_traffic(input int target, input int read_pct, input int len_top);
		int counted, pick, len, kind;
		logic [7:0] sum, b;
		counted = 0;
		while (counted < target) begin
			pick = $urandom_range(99);
			if (pick < read_pct) begin
				put(CMD_READ, 8'($urandom));
				counted++;
			end else if (pick < read_pct + 8) begin
				b = 8'($urandom);
				if (b == cfg_start)
					b = ~b;
				put(CMD_RX, b);
			end else begin
				kind = $urandom_range(9);
				len = ($urandom_range(15) == 0) ? LEN_MAX :
					$urandom_range(len_top, fsr_pkg::MIN_LEN);
				put(CMD_RX, cfg_start);
				if (kind == 0) begin
					len = $urandom_range(1) ? $urandom_range(fsr_pkg::MIN_LEN - 1, 0) :
						$urandom_range(255, LEN_MAX + 1);
					put(CMD_RX, 8'(len));
					counted += 2;
				end else begin
					sum = 8'(len);
					put(CMD_RX, 8'(len));
					for (int i = 0; i < len - fsr_pkg::MIN_LEN; i++) begin
						if ($urandom_range(19) == 0) begin
							put(CMD_READ, 8'($urandom));
							counted++;
						end
						b = 8'($urandom);
						sum ^= b;
						put(CMD_RX, b);
					end
					if (kind == 1)
						sum ^= 8'($urandom_range(255, 1));
					put(CMD_RX, sum);
					put(CMD_RX, (kind == 2) ? cfg_stop ^ 8'($urandom_range(255, 1)) : cfg_stop);
					counted += len;
				end
			end
		end
	endtask

	task automatic settle(input int extra);
		while (stim_q.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic apb_write(input logic idx, input logic [7:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == fsr_pkg::REG_START)
			cfg_start = val;
		else
			cfg_stop = val;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (!s_tvalid || took) begin
			if (stim_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				bus_row = stim_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= bus_row.cmd;
				s_tdata <= bus_row.b;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= ($urandom_range(99) >= dst_idle_pct);
	end

	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = fsr_pkg::status_t'(m_tuser[2:0]);
			got.valid = m_tuser[3];
			got.data = m_tdata[7:0];
			got.held = m_tdata[10:8];
			got.flen = m_tdata[16:11];
			got.last = m_tlast;
			if (expected_results.size() == 0) begin
				$error("result with no item waiting for it: status %0d", int'(got.status));
				failures++;
			end else begin
				want = expected_results.pop_front();
				compare_field("status", int'(want.status), int'(got.status));
				compare_field("data_byte", int'(want.data), int'(got.data));
				compare_field("byte_valid", int'(want.valid), int'(got.valid));
				compare_field("last", int'(want.last), int'(got.last));
				compare_field("frames_held", int'(want.held), int'(got.held));
				compare_field("frame_length", int'(want.flen), int'(got.flen));
				results_checked++;
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			absorb(bus_row);
			items_taken++;
			took = 1'b1;
		end else begin
			took = 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		apb_write(fsr_pkg::REG_START, 8'h02);
		apb_write(fsr_pkg::REG_STOP, 8'h03);
		src_idle_pct = 13;
		dst_idle_pct = 70;
		foreach (directed_rows[i])
			stim_q.push_back(directed_rows[i]);
		queue_traffic(10, 35, 10);
		settle(SETTLE_CYCLES);

		// Reads come only rarely, inside long frames, so short frames pile up until the ring refuses them.
		apb_write(fsr_pkg::REG_START, 8'h00);
		apb_write(fsr_pkg::REG_STOP, 8'hFF);
		src_idle_pct = 70;
		dst_idle_pct = 13;
		queue_traffic(45, 0, 4);
		settle(SETTLE_CYCLES);

		apb_write(fsr_pkg::REG_START, 8'hFF);
		apb_write(fsr_pkg::REG_STOP, 8'h00);
		src_idle_pct = 0;
		dst_idle_pct = 0;
		queue_traffic(10, 50, 10);
		settle(SETTLE_CYCLES);

		apb_write(fsr_pkg::REG_START, 8'($urandom));
		apb_write(fsr_pkg::REG_STOP, 8'($urandom));
		queue_traffic(10, 40, 10);
		settle(DRAIN_CYCLES);

		$display("Sent %0d items under four start/stop settings and checked %0d results.",
			items_taken, results_checked);
		$display("Frames refused by a full ring: %0d; mismatches: %0d.", full_drops, failures);
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ sim.f @@
design/fsr_pkg.sv
design/fsr_front.sv
design/fsr_queue.sv
design/fsr_back.sv
design/framed_serial_receiver_ring.sv
tb/tb_framed_serial_receiver_ring.sv
